### hw/rtl/pvd_pkg.sv
// Shared types and constants for the prefix varint decoder.
// Holds the front-end phase encoding, the command format passed from the
// front end to the back end, and the command queue sizing. No dependencies.
package pvd_pkg;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic [7:0] LeadMulti  = 8'h80;
  localparam logic [7:0] Lead3      = 8'hC0;
  localparam logic [7:0] Lead4      = 8'hE0;
  localparam logic [7:0] Lead5      = 8'hF0;
  localparam logic [7:0] NarrowBad  = 8'hF1;
  localparam logic [7:0] Lead6      = 8'hF8;
  localparam logic [7:0] Lead7      = 8'hFC;
  localparam logic [7:0] LeadSeven  = 8'hFE;
  localparam logic [7:0] LeadExt    = 8'hFF;
  localparam logic [7:0] SecondLong = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_SECOND  = 3'b010,
    PH_COLLECT = 3'b100
  } phase_e;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SHIFT,
    OP_SHIFT_EMIT,
    OP_EMIT,
    OP_ERROR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [3:0] count;
  } cmd_t;

endpackage

### hw/rtl/prefix_varint_decoder.sv
// Top level of the prefix varint decoder: width register, front end,
// command queue and back end. Depends on pvd_pkg, pvd_front,
// pvd_cmd_fifo and pvd_back.
//
// Usage: bytes of the encoded stream enter on in_byte_i, taken at an edge
// with push high and full low. Decoded numbers leave as a queue: while
// empty is low, value_o, byte_count_o and error_o show the oldest result,
// removed at an edge with pop high. A byte that finishes a number is
// queued as a command, then its result is registered; one byte is taken
// every cycle while full is low. The accumulator shift in the back end
// sets the throughput, one command per cycle unless a held result stalls
// it; a two-entry command queue sits in between. When pop stays low a
// result holds in the output register; the back end stops at the next
// byte that finishes a number, the queue fills behind it and full rises.
// cfg_wide_mode_i is written at an edge with cfg_valid_i and cfg_ready_o
// high; cfg_ready_o is always high. It is sampled with each lead byte.
// Reset empties the queue and the output register, selects 64-bit mode
// and makes the next byte a lead byte.
module prefix_varint_decoder import pvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value_o,
  output logic [3:0]  byte_count_o,
  output logic        error_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_wide_mode_i
);

  logic wide_q;
  logic fire;
  cmd_t front_cmd, head_cmd;
  logic q_empty, q_take, res_valid;

  assign cfg_ready_o = 1'b1;
  assign fire        = push && !full;
  assign empty       = !res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wide_q <= cfg_wide_mode_i;
    end
  end

  pvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .in_byte_i   (in_byte_i),
    .wide_mode_i (wide_q),
    .cmd_o       (front_cmd)
  );

  pvd_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (push),
    .wr_cmd_i (front_cmd),
    .full_o   (full),
    .rd_i     (q_take),
    .rd_cmd_o (head_cmd),
    .empty_o  (q_empty)
  );

  pvd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .cmd_avail_i  (!q_empty),
    .cmd_take_o   (q_take),
    .pop_i        (pop),
    .res_valid_o  (res_valid),
    .value_o      (value_o),
    .byte_count_o (byte_count_o),
    .error_o      (error_o)
  );

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (value_o == 64'd0))
    else $error("error result with nonzero value");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (byte_count_o != 4'd0 && byte_count_o <= 4'd10))
    else $error("byte count out of range");

  a_single_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !error_o && byte_count_o == 4'd1) |-> (value_o < 64'd128))
    else $error("one-byte number above 0x7F");

  a_take_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> !q_empty)
    else $error("back end took from empty queue");
`endif

endmodule

### hw/rtl/pvd_front.sv
// Front end of the prefix varint decoder: tracks the lead-byte phase and
// turns each accepted byte into a command for the back end.
// Depends on pvd_pkg.
module pvd_front import pvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] in_byte_i,
  input  logic       wide_mode_i,
  output cmd_t       cmd_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic [3:0] seen_q, seen_d;
  logic [7:0] mask;
  logic [3:0] n;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    seen_d     = seen_q;
    mask       = 8'h00;
    n          = 4'd0;
    cmd_o.op    = OP_LOAD;
    cmd_o.data  = 8'h00;
    cmd_o.count = 4'd1;
    unique case (phase_q)
      PH_COLLECT: begin
        seen_d      = seen_q + 4'd1;
        left_d      = left_q - 4'd1;
        cmd_o.data  = in_byte_i;
        cmd_o.count = seen_d;
        if (left_q == 4'd1) begin
          cmd_o.op = OP_SHIFT_EMIT;
          phase_d  = PH_IDLE;
        end else begin
          cmd_o.op = OP_SHIFT;
        end
      end
      PH_SECOND: begin
        seen_d      = 4'd2;
        cmd_o.count = 4'd2;
        if (in_byte_i < SecondLong) begin
          cmd_o.op   = OP_LOAD;
          cmd_o.data = in_byte_i;
          left_d     = 4'd7;
          phase_d    = PH_COLLECT;
        end else if (in_byte_i == SecondLong) begin
          cmd_o.op   = OP_LOAD;
          left_d     = 4'd8;
          phase_d    = PH_COLLECT;
        end else begin
          cmd_o.op   = OP_ERROR;
          phase_d    = PH_IDLE;
        end
      end
      default: begin
        seen_d = 4'd1;
        priority if (in_byte_i < LeadMulti) begin
          cmd_o.op   = OP_EMIT;
          cmd_o.data = in_byte_i;
        end else if (in_byte_i < Lead3) begin
          n = 4'd1; mask = 8'h3F;
        end else if (in_byte_i < Lead4) begin
          n = 4'd2; mask = 8'h1F;
        end else if (in_byte_i < Lead5) begin
          n = 4'd3; mask = 8'h0F;
        end else if (!wide_mode_i) begin
          if (in_byte_i < NarrowBad) begin
            n = 4'd4;
          end else begin
            cmd_o.op = OP_ERROR;
          end
        end else if (in_byte_i < Lead6) begin
          n = 4'd4; mask = 8'h07;
        end else if (in_byte_i < Lead7) begin
          n = 4'd5; mask = 8'h03;
        end else if (in_byte_i < LeadSeven) begin
          n = 4'd6; mask = 8'h01;
        end else if (in_byte_i < LeadExt) begin
          n = 4'd7;
        end else begin
          phase_d = PH_SECOND;
          left_d  = 4'd0;
        end
        if (n != 4'd0) begin
          cmd_o.data = in_byte_i & mask;
          left_d     = n;
          phase_d    = PH_COLLECT;
        end
        if (cmd_o.op == OP_EMIT || cmd_o.op == OP_ERROR) begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      left_q  <= 4'd0;
      seen_q  <= 4'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
    end
  end

endmodule

### hw/rtl/pvd_cmd_fifo.sv
// Short command queue between the front end and the back end of the
// prefix varint decoder. Depth set by pvd_pkg::CmdDepth.
// Depends on pvd_pkg.
module pvd_cmd_fifo import pvd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_cmd_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_cmd_o,
  output logic empty_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] cnt_q;
  logic               do_wr, do_rd;

  assign full_o   = (cnt_q == CmdCntW'(CmdDepth));
  assign empty_o  = (cnt_q == '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && !empty_o;
  assign rd_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/pvd_back.sv
// Back end of the prefix varint decoder: executes queued commands on the
// 64-bit accumulator and holds finished results in an output register.
// Depends on pvd_pkg.
module pvd_back import pvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_avail_i,
  output logic        cmd_take_o,
  input  logic        pop_i,
  output logic        res_valid_o,
  output logic [63:0] value_o,
  output logic [3:0]  byte_count_o,
  output logic        error_o
);

  logic [63:0] acc_q, acc_d;
  logic        valid_q;
  logic [63:0] value_q, value_d;
  logic [3:0]  count_q;
  logic        error_q, error_d;
  logic        emits, pop_hit;

  assign emits   = (cmd_i.op == OP_SHIFT_EMIT) || (cmd_i.op == OP_EMIT) ||
                   (cmd_i.op == OP_ERROR);
  assign pop_hit = pop_i && valid_q;
  assign cmd_take_o = cmd_avail_i && (!emits || !valid_q || pop_hit);

  always_comb begin
    acc_d   = acc_q;
    value_d = 64'd0;
    error_d = 1'b0;
    unique case (cmd_i.op)
      OP_LOAD:       acc_d   = {56'd0, cmd_i.data};
      OP_SHIFT:      acc_d   = {acc_q[55:0], cmd_i.data};
      OP_SHIFT_EMIT: value_d = {acc_q[55:0], cmd_i.data};
      OP_EMIT:       value_d = {56'd0, cmd_i.data};
      OP_ERROR:      error_d = 1'b1;
      default:       acc_d   = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= 64'd0;
    end else begin
      if (cmd_take_o) begin
        acc_q <= acc_d;
      end
      if (cmd_take_o && emits) begin
        valid_q <= 1'b1;
      end else if (pop_hit) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && emits) begin
      value_q <= value_d;
      count_q <= cmd_i.count;
      error_q <= error_d;
    end
  end

  assign res_valid_o  = valid_q;
  assign value_o      = value_q;
  assign byte_count_o = count_q;
  assign error_o      = error_q;

endmodule
